// File: hdl/thc_pkg.sv
`default_nettype none
package thc_pkg;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_KEY  = 1'b1
  } req_kind_t;

  localparam logic [7:0] KEY_HOURS   = 8'h41;  // 'A'
  localparam logic [7:0] KEY_MINUTES = 8'h42;  // 'B'
  localparam logic [7:0] KEY_SECONDS = 8'h43;  // 'C'
  localparam logic [7:0] KEY_RESET   = 8'h44;  // 'D'

  localparam logic [7:0] TPS_RESET  = 8'd100;
  localparam logic [5:0] SEXA_MAX   = 6'd59;
  localparam logic [3:0] HOUR_MAX   = 4'd12;
  localparam logic [3:0] HOUR_RESET = 4'd11;

  typedef struct packed {
    logic [7:0] tick_count;
    logic [5:0] second_count;
    logic [5:0] minute_count;
    logic [3:0] hour_count;
    logic       am_flag;
  } time_state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] key;
  } req_t;

  typedef struct packed {
    logic [3:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       is_am;
    logic       hours_tens;
    logic [3:0] hours_ones;
    logic [2:0] minutes_tens;
    logic [3:0] minutes_ones;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_ones;
    logic       second_elapsed;
  } res_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } bcd6_t;

  // Split a value below 64 into decimal digits by a compare chain.
  function automatic bcd6_t bcd6(input logic [5:0] v);
    bcd6_t      d;
    logic [5:0] rest;
    if (v >= 6'd60) d.tens = 3'd6;
    else if (v >= 6'd50) d.tens = 3'd5;
    else if (v >= 6'd40) d.tens = 3'd4;
    else if (v >= 6'd30) d.tens = 3'd3;
    else if (v >= 6'd20) d.tens = 3'd2;
    else if (v >= 6'd10) d.tens = 3'd1;
    else d.tens = 3'd0;
    rest   = v - 6'({3'd0, d.tens} * 6'd10);
    d.ones = rest[3:0];
    return d;
  endfunction

endpackage
`default_nettype wire

// File: hdl/thc_req_if.sv
`default_nettype none
interface thc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] key;

  modport source (output valid, req_type, key, input ready);
  modport sink (input valid, req_type, key, output ready);
endinterface
`default_nettype wire

// File: hdl/thc_res_if.sv
`default_nettype none
interface thc_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic       is_am;
  logic       hours_tens;
  logic [3:0] hours_ones;
  logic [2:0] minutes_tens;
  logic [3:0] minutes_ones;
  logic [2:0] seconds_tens;
  logic [3:0] seconds_ones;
  logic       second_elapsed;

  modport source (
    output valid, hours, minutes, seconds, is_am, hours_tens, hours_ones,
           minutes_tens, minutes_ones, seconds_tens, seconds_ones, second_elapsed,
    input  ready
  );
  modport sink (
    input  valid, hours, minutes, seconds, is_am, hours_tens, hours_ones,
           minutes_tens, minutes_ones, seconds_tens, seconds_ones, second_elapsed,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/thc_step.sv
`default_nettype none
module thc_step (
  input  var thc_pkg::time_state_t state,
  input  var thc_pkg::req_t        req,
  input  var logic [7:0]           tps,
  output thc_pkg::time_state_t     state_nxt,
  output thc_pkg::res_t            res
);
  import thc_pkg::*;

  logic [8:0] tick_inc;
  logic       do_sec;
  logic       do_min;
  logic       do_hour;
  logic       elapsed;
  bcd6_t      min_d;
  bcd6_t      sec_d;
  logic [3:0] hour_ones;

  always_comb begin
    state_nxt = state;
    tick_inc  = {1'b0, state.tick_count} + 9'd1;
    do_sec    = 1'b0;
    do_min    = 1'b0;
    do_hour   = 1'b0;
    elapsed   = 1'b0;

    if (req.req_type == REQ_TICK) begin
      if (tick_inc >= {1'b0, tps}) begin
        state_nxt.tick_count = '0;
        elapsed              = 1'b1;
        do_sec               = 1'b1;
      end else begin
        state_nxt.tick_count = tick_inc[7:0];
      end
    end else begin
      unique case (req.key)
        KEY_HOURS: begin
          state_nxt.hour_count = state.hour_count + 4'd1;
          if (state_nxt.hour_count > HOUR_MAX) begin
            state_nxt.hour_count = 4'd1;
            state_nxt.am_flag    = ~state.am_flag;
          end
        end
        KEY_MINUTES: do_min = 1'b1;
        KEY_SECONDS: do_sec = 1'b1;
        KEY_RESET: begin
          state_nxt.hour_count   = HOUR_MAX;
          state_nxt.minute_count = '0;
          state_nxt.second_count = '0;
          state_nxt.am_flag      = 1'b1;
        end
        default: ;
      endcase
    end

    // Carry chain: seconds into minutes into hours.
    if (do_sec) begin
      state_nxt.second_count = state.second_count + 6'd1;
      if (state_nxt.second_count > SEXA_MAX) begin
        state_nxt.second_count = '0;
        do_min                 = 1'b1;
      end
    end
    if (do_min) begin
      state_nxt.minute_count = state.minute_count + 6'd1;
      if (state_nxt.minute_count > SEXA_MAX) begin
        state_nxt.minute_count = '0;
        do_hour                = 1'b1;
      end
    end
    if (do_hour) begin
      state_nxt.hour_count = state.hour_count + 4'd1;
      if (state_nxt.hour_count > HOUR_MAX) begin
        state_nxt.hour_count = 4'd1;
      end else if (state_nxt.hour_count == HOUR_MAX) begin
        state_nxt.am_flag = ~state.am_flag;
      end
    end
  end

  assign min_d     = bcd6(state_nxt.minute_count);
  assign sec_d     = bcd6(state_nxt.second_count);
  assign hour_ones = (state_nxt.hour_count >= 4'd10) ? state_nxt.hour_count - 4'd10
                                                     : state_nxt.hour_count;

  always_comb begin
    res.hours          = state_nxt.hour_count;
    res.minutes        = state_nxt.minute_count;
    res.seconds        = state_nxt.second_count;
    res.is_am          = state_nxt.am_flag;
    res.hours_tens     = (state_nxt.hour_count >= 4'd10);
    res.hours_ones     = hour_ones;
    res.minutes_tens   = min_d.tens;
    res.minutes_ones   = min_d.ones;
    res.seconds_tens   = sec_d.tens;
    res.seconds_ones   = sec_d.ones;
    res.second_elapsed = elapsed;
  end

endmodule
`default_nettype wire

// File: hdl/twelve_hour_clock_with_set_keys.sv
// Pipeline: a result beat passes the input register and then the result register;
// it is valid once it reaches the result register, where it holds until taken.
// Throughput: one beat per cycle while out_ch.ready holds; the time update is a
// single compare/carry pass between the input register and the result register.
// Reset (rst_n low, synchronous): time 11:59:59 PM, tick count 0, ticks per
// second 100, both pipeline registers empty.
`default_nettype none
module twelve_hour_clock_with_set_keys (
  input  var logic       clk,
  input  var logic       rst_n,
  thc_req_if.sink        in_ch,
  thc_res_if.source      out_ch,
  input  var logic       cfg_we,
  input  var logic [7:0] cfg_wdata
);
  import thc_pkg::*;

  // Configuration: prescaler ticks per second.
  logic [7:0] tps_r;

  // Input stage: one captured beat waiting for the update pass.
  logic s1_valid_r;
  logic s1_valid_nxt;
  req_t s1_req_r;

  // Clock state, updated only when the input stage hands its beat on.
  time_state_t state_r;
  time_state_t state_nxt;

  // Result stage.
  logic out_valid_r;
  logic out_valid_nxt;
  res_t res_r;
  res_t res_nxt;

  logic in_fire;
  logic s1_adv;
  logic s1_fire;

  // The result register frees up when it is empty or its beat is taken now,
  // so both sides can stream one beat per cycle.
  assign s1_adv      = ~out_valid_r | out_ch.ready;
  assign s1_fire     = s1_valid_r & s1_adv;
  assign in_ch.ready = ~s1_valid_r | s1_adv;
  assign in_fire     = in_ch.valid & in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Single pass: tick/key decode, carry chain and decimal split.
  thc_step u_step (
    .state     (state_r),
    .req       (s1_req_r),
    .tps       (tps_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  // Control and clock state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r               <= TPS_RESET;
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      state_r.tick_count   <= '0;
      state_r.second_count <= SEXA_MAX;
      state_r.minute_count <= SEXA_MAX;
      state_r.hour_count   <= HOUR_RESET;
      state_r.am_flag      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      // Advance the time only when the update result moves into the result stage.
      if (s1_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers: no reset, loaded on their stage's handshake.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.req_type <= in_ch.req_type;
      s1_req_r.key      <= in_ch.key;
    end
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hours          = res_r.hours;
  assign out_ch.minutes        = res_r.minutes;
  assign out_ch.seconds        = res_r.seconds;
  assign out_ch.is_am          = res_r.is_am;
  assign out_ch.hours_tens     = res_r.hours_tens;
  assign out_ch.hours_ones     = res_r.hours_ones;
  assign out_ch.minutes_tens   = res_r.minutes_tens;
  assign out_ch.minutes_ones   = res_r.minutes_ones;
  assign out_ch.seconds_tens   = res_r.seconds_tens;
  assign out_ch.seconds_ones   = res_r.seconds_ones;
  assign out_ch.second_elapsed = res_r.second_elapsed;

  // Time fields stay in their legal ranges.
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.hour_count >= 4'd1 && state_r.hour_count <= HOUR_MAX)
    else $error("hour count out of range");

  a_min_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.minute_count <= SEXA_MAX && state_r.second_count <= SEXA_MAX)
    else $error("minute or second count out of range");

  // Time only moves when a beat passes the update stage.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(state_r))
    else $error("clock state changed without an update");

  // A completed second clears the prescaler count.
  a_elapsed_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res_nxt.second_elapsed |=> state_r.tick_count == 8'd0)
    else $error("tick count not cleared on elapsed second");

  // Result shown matches the held clock state after an update.
  a_res_matches: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> res_r.hours == state_r.hour_count && res_r.is_am == state_r.am_flag)
    else $error("result does not match clock state");

endmodule
`default_nettype wire
